>>> rtl/sha256_pkg.sv
// SHA-256 hash engine: shared types, constants and bit functions.
// Depends on nothing; imported by every module of the engine.
`default_nettype none

package sha256_pkg;

   localparam int LENGTH_BITS = 64;
   localparam logic [63:0] LEN_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - LENGTH_BITS);

   localparam logic [31:0] PAD_ONE = 32'h8000_0000;

   localparam logic [31:0] INIT_HASH [0:7] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_UPDATE,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic       push;
      logic       load_vars;
      logic       round_en;
      logic [5:0] round_idx;
      logic       update;
      logic       rearm;
      logic [2:0] out_idx;
   } ctrl_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

`default_nettype wire

>>> rtl/sha256_datapath.sv
// SHA-256 round datapath: schedule window, working variables, hash state.
// Depends on sha256_pkg; driven by the sequencer in sha256_ctrl.
`default_nettype none

module sha256_datapath
   import sha256_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ctrl_type    ctrl,
   input  wire logic [31:0] push_data,
   output logic [31:0]      digest_word
);

   logic [31:0] w_ff    [0:15];
   logic [31:0] vars_ff [0:7];
   logic [31:0] hash_ff [0:7];

   logic [31:0] w_next;
   logic [31:0] t1;
   logic [31:0] t2;
   logic [31:0] ch;
   logic [31:0] maj;

   // next schedule word W[t+16] from the sliding window
   assign w_next = small_sigma1(w_ff[14]) + w_ff[9] + small_sigma0(w_ff[1]) + w_ff[0];

   assign ch  = (vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]);
   assign maj = (vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
              ^ (vars_ff[1] & vars_ff[2]);
   assign t1  = vars_ff[7] + big_sigma1(vars_ff[4]) + ch + ROUND_K[ctrl.round_idx] + w_ff[0];
   assign t2  = big_sigma0(vars_ff[0]) + maj;

   assign digest_word = hash_ff[ctrl.out_idx];

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
         w_ff[15] <= push_data;
      end else if (ctrl.round_en) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
         w_ff[15] <= w_next;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_vars) begin
         for (int i = 0; i < 8; i++) vars_ff[i] <= hash_ff[i];
      end else if (ctrl.round_en) begin
         vars_ff[7] <= vars_ff[6];
         vars_ff[6] <= vars_ff[5];
         vars_ff[5] <= vars_ff[4];
         vars_ff[4] <= vars_ff[3] + t1;
         vars_ff[3] <= vars_ff[2];
         vars_ff[2] <= vars_ff[1];
         vars_ff[1] <= vars_ff[0];
         vars_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.rearm) begin
         for (int i = 0; i < 8; i++) hash_ff[i] <= INIT_HASH[i];
      end else if (ctrl.update) begin
         for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + vars_ff[i];
      end
   end

endmodule

`default_nettype wire

>>> rtl/sha256_ctrl.sv
// SHA-256 sequencer: word slot, round counter, byte total, padding and output.
// Depends on sha256_pkg; steers sha256_datapath through ctrl_type.
`default_nettype none

module sha256_ctrl
   import sha256_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_data_word,
   input  wire logic [2:0]  req_byte_count,
   input  wire logic        req_last_word,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output ctrl_type         ctrl,
   output logic [31:0]      push_data
);

   state_type   state_ff, state_in;
   logic [3:0]  wp_ff, wp_in;
   logic [5:0]  round_ff, round_in;
   logic [60:0] total_ff, total_in;
   logic        pend80_ff, pend80_in;
   logic        hi_done_ff, hi_done_in;
   logic        len_done_ff, len_done_in;
   logic        finish_ff, finish_in;
   logic [2:0]  out_idx_ff, out_idx_in;

   logic        accept;
   logic        rsp_xfer;
   logic        push;
   logic        wrap;
   logic        done;
   logic [2:0]  count;
   logic [63:0] len_bits;

   function automatic logic [31:0] tail_word(input logic [31:0] d, input logic [1:0] n);
      logic [31:0] r;
      unique case (n)
         2'd0:    r = 32'h8000_0000;
         2'd1:    r = {d[31:24], 24'h80_0000};
         2'd2:    r = {d[31:16], 16'h8000};
         default: r = {d[31:8], 8'h80};
      endcase
      return r;
   endfunction

   assign accept   = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;
   assign count    = (req_byte_count > 3'd4) ? 3'd4 : req_byte_count;
   assign len_bits = {total_ff, 3'b000} & LEN_MASK;
   assign wrap     = push && (wp_ff == 4'd15);
   assign done     = rsp_xfer && (out_idx_ff == 3'd7);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (wrap) state_in = ST_ROUND;
               else if (req_last_word) state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            if (wrap) state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (round_ff == 6'd63) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            priority if (len_done_ff) state_in = ST_OUTPUT;
            else if (finish_ff) state_in = ST_PAD;
            else state_in = ST_IDLE;
         end
         ST_OUTPUT: begin
            if (done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and word pushes
   always_comb begin
      push      = 1'b0;
      push_data = '0;
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_OUTPUT);
      unique case (state_ff)
         ST_IDLE: begin
            push = accept;
            if (!req_last_word || count == 3'd4) push_data = req_data_word;
            else push_data = tail_word(req_data_word, count[1:0]);
         end
         ST_PAD: begin
            push = 1'b1;
            priority if (pend80_ff) push_data = PAD_ONE;
            else if (!hi_done_ff && wp_ff != 4'd14) push_data = '0;
            else if (!hi_done_ff) push_data = len_bits[63:32];
            else push_data = len_bits[31:0];
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   // bookkeeping
   always_comb begin
      wp_in       = push ? wp_ff + 4'd1 : wp_ff;
      round_in    = (state_ff == ST_ROUND) ? round_ff + 6'd1 : round_ff;
      total_in    = total_ff;
      pend80_in   = pend80_ff;
      hi_done_in  = hi_done_ff;
      len_done_in = len_done_ff;
      finish_in   = finish_ff;
      out_idx_in  = rsp_xfer ? out_idx_ff + 3'd1 : out_idx_ff;
      if (accept) begin
         if (req_last_word) begin
            total_in  = total_ff + 61'(count);
            pend80_in = (count == 3'd4);
            finish_in = 1'b1;
         end else begin
            total_in = total_ff + 61'd4;
         end
      end
      if (state_ff == ST_PAD) begin
         priority if (pend80_ff) pend80_in = 1'b0;
         else if (!hi_done_ff && wp_ff != 4'd14) pend80_in = 1'b0;
         else if (!hi_done_ff) hi_done_in = 1'b1;
         else len_done_in = 1'b1;
      end
      if (done) begin
         total_in    = '0;
         hi_done_in  = 1'b0;
         len_done_in = 1'b0;
         finish_in   = 1'b0;
         wp_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         wp_ff       <= '0;
         round_ff    <= '0;
         total_ff    <= '0;
         pend80_ff   <= 1'b0;
         hi_done_ff  <= 1'b0;
         len_done_ff <= 1'b0;
         finish_ff   <= 1'b0;
         out_idx_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         wp_ff       <= wp_in;
         round_ff    <= round_in;
         total_ff    <= total_in;
         pend80_ff   <= pend80_in;
         hi_done_ff  <= hi_done_in;
         len_done_ff <= len_done_in;
         finish_ff   <= finish_in;
         out_idx_ff  <= out_idx_in;
      end
   end

   assign ctrl.push      = push;
   assign ctrl.load_vars = wrap;
   assign ctrl.round_en  = (state_ff == ST_ROUND);
   assign ctrl.round_idx = round_ff;
   assign ctrl.update    = (state_ff == ST_UPDATE);
   assign ctrl.rearm     = done;
   assign ctrl.out_idx   = out_idx_ff;

   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("input ready while digest is presented");

   a_block_start: assert property (@(posedge clock) disable iff (reset)
      wrap |=> (state_ff == ST_ROUND) && (round_ff == 6'd0))
      else $error("full block did not start compression at round zero");

   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) && (round_ff == 6'd63) |=> (state_ff == ST_UPDATE))
      else $error("compression did not end after round 63");

   a_len_slot: assert property (@(posedge clock) disable iff (reset)
      len_done_ff |-> (wp_ff == 4'd0))
      else $error("length trailer not at end of block");

endmodule

`default_nettype wire

>>> rtl/sha256_hash_engine_unit.sv
// SHA-256 hash engine top level: ctrl sequencer plus shared round datapath.
// The sixteenth word of a block starts a compression (64 rounds on the one round unit,
// then the hash add); no new word is taken until it is done.
// A final word adds padding words and one or two compressions,
// then 8 digest transfers. Synchronous reset loads the initial hash values,
// clears the byte total and word slot; no clearing pass is needed.
`default_nettype none

module sha256_hash_engine_unit
   import sha256_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_data_word,
   input  wire logic [2:0]  req_byte_count,
   input  wire logic        req_last_word,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_digest_last
);

   ctrl_type    ctrl;
   logic [31:0] push_data;

   sha256_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last_word  (req_last_word),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .ctrl           (ctrl),
      .push_data      (push_data)
   );

   sha256_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .push_data   (push_data),
      .digest_word (rsp_digest_word)
   );

   assign rsp_word_index  = ctrl.out_idx;
   assign rsp_digest_last = (ctrl.out_idx == 3'd7);

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for sha256_hash_engine_unit: messages go in as words,
// and each eight-word digest is checked against a SHA-256 computed here.
// Depends on rtl/sha256_pkg.sv and rtl/sha256_hash_engine_unit.sv.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned DRAIN_CYCLES = 200;
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   localparam int unsigned PHASE_WORDS = 150;

   localparam logic [31:0] SHA_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        closing;
   } digest_word_type;

   class digest_scoreboard;
      logic [31:0]     chain [8];
      logic [31:0]     block_buf [16];
      int unsigned     fill;
      logic [60:0]     byte_total;
      digest_word_type expected_digest [$];
      int unsigned     errors;

      function new();
         chain = SHA_IV;
         fill = 0;
         byte_total = '0;
         errors = 0;
      endfunction

      function logic [31:0] ror(logic [31:0] x, int unsigned n);
         return (x >> n) | (x << (32 - n));
      endfunction

      function void compress();
         logic [31:0] sched [64];
         logic [31:0] v [8];
         logic [31:0] s0, s1, t1, t2;
         for (int i = 0; i < 16; i++) sched[i] = block_buf[i];
         for (int i = 16; i < 64; i++) begin
            s0 = ror(sched[i-15], 7) ^ ror(sched[i-15], 18) ^ (sched[i-15] >> 3);
            s1 = ror(sched[i-2], 17) ^ ror(sched[i-2], 19) ^ (sched[i-2] >> 10);
            sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
         end
         v = chain;
         for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + sched[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
         end
         for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
      endfunction

      function void absorb(logic [31:0] w);
         block_buf[fill] = w;
         fill = (fill + 1) % 16;
         if (fill == 0) compress();
      endfunction

      // Note one accepted input transfer; a final word queues its digest.
      task take_word(logic [31:0] data, logic [2:0] count, logic is_last);
         int unsigned nbytes;
         logic [31:0] keep;
         logic [63:0] bit_len;
         digest_word_type entry;
         if (!is_last) begin
            // a short count on a non-final word is ignored
            byte_total = byte_total + 61'd4;
            absorb(data);
            return;
         end
         nbytes = (count > 3'd4) ? 4 : count;
         byte_total = byte_total + 61'(nbytes);
         if (nbytes == 4) begin
            absorb(data);
            absorb(32'h8000_0000);
         end else begin
            keep = (nbytes == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * nbytes));
            absorb((data & keep) | (32'h80 << (24 - 8 * nbytes)));
         end
         // no room for the length: zero-fill into a second block
         if (fill > 14) absorb(32'h0);
         while (fill < 14) absorb(32'h0);
         bit_len = {byte_total, 3'b000};
         absorb(bit_len[63:32]);
         absorb(bit_len[31:0]);
         for (int i = 0; i < 8; i++) begin
            entry.word = chain[i];
            entry.index = 3'(i);
            entry.closing = (i == 7);
            expected_digest.push_back(entry);
         end
         chain = SHA_IV;
         fill = 0;
         byte_total = '0;
      endtask

      task flag_mismatch(string what);
         errors++;
         if (errors <= 100) $display("mismatch: %s", what);
      endtask

      task check_digest(logic [31:0] word, logic [2:0] index, logic closing);
         digest_word_type want;
         if (expected_digest.size() == 0) begin
            flag_mismatch($sformatf("unexpected digest word %h index %0d", word, index));
            return;
         end
         want = expected_digest.pop_front();
         if (word !== want.word || index !== want.index || closing !== want.closing)
            flag_mismatch($sformatf("digest word %0d: got %h/%0d/%0d, expected %h/%0d/%0d",
               want.index, word, index, closing, want.word, want.index, want.closing));
      endtask

      task report_leftovers();
         digest_word_type want;
         while (expected_digest.size() != 0) begin
            want = expected_digest.pop_front();
            flag_mismatch($sformatf("digest word %0d (%h) never arrived", want.index, want.word));
         end
      endtask

      function int unsigned pending();
         return expected_digest.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_data_word = '0;
   logic [2:0]  req_byte_count = '0;
   logic        req_last_word = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_digest_last;

   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned words_sent = 0;
   bit          pressure_armed = 1'b0;
   digest_scoreboard sb;

   sha256_hash_engine_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_word   (req_data_word),
      .req_byte_count  (req_byte_count),
      .req_last_word   (req_last_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_digest_last (rsp_digest_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_digest(rsp_digest_word, rsp_word_index, rsp_digest_last);
         if (req_valid && req_ready)
            sb.take_word(req_data_word, req_byte_count, req_last_word);
      end
   end

   initial begin : receiver
      int unsigned stall_left;
      bit pressure_done;
      stall_left = 0;
      pressure_done = 1'b0;
      forever begin
         @(posedge clock);
         if (pressure_armed && !pressure_done) begin
            stall_left = HOLD_OFF_CYCLES;
            pressure_done = 1'b1;
         end
         if (stall_left != 0) begin
            // hold off so the engine backs up into its input
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("status: fail");
      $finish;
   end

   // Offer one word and hold it until the transfer; valid stays high into the next call.
   task automatic send_word(input logic [31:0] data, input logic [2:0] count,
                            input logic is_last);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid <= 1'b1;
      req_data_word <= data;
      req_byte_count <= count;
      req_last_word <= is_last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic send_message(input int unsigned n_words);
      logic [2:0] count;
      for (int unsigned i = 1; i <= n_words; i++) begin
         if (i == n_words || $urandom_range(9) == 0) count = 3'($urandom_range(7));
         else count = 3'd4;
         send_word($urandom, count, i == n_words);
      end
   endtask

   task automatic run_phase(input int unsigned req_pct, input int unsigned rsp_pct);
      int unsigned goal;
      int unsigned n_words;
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      goal = words_sent + PHASE_WORDS;
      while (words_sent < goal) begin
         case ($urandom_range(9))
            0:       n_words = 1;
            1, 2:    n_words = $urandom_range(13, 16);   // around the two-block padding edge
            3:       n_words = $urandom_range(17, 40);
            default: n_words = $urandom_range(2, 12);
         endcase
         send_message(n_words);
      end
   endtask

   initial begin : stimulus
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      req_idle_pct = 6;
      rsp_idle_pct = 52;

      send_word(32'hffff_ffff, 3'd0, 1'b1);      // empty message, junk data
      send_word(32'h6162_63ff, 3'd3, 1'b1);      // "abc" with junk in the dropped byte
      send_word(32'hffff_ffff, 3'd4, 1'b1);
      send_word(32'h0000_0000, 3'd4, 1'b1);
      send_word(32'h1234_5678, 3'd5, 1'b1);      // oversized counts clamp to four
      send_word(32'h9abc_def0, 3'd6, 1'b1);
      send_word(32'hffff_ffff, 3'd7, 1'b1);
      send_word(32'hdead_beef, 3'd1, 1'b0);      // short counts on non-final words
      send_word(32'h0000_0000, 3'd0, 1'b0);
      send_word(32'ha5a5_a5a5, 3'd2, 1'b1);
      send_word(32'h00ff_ffff, 3'd1, 1'b1);
      // thirteen full words then a full last word: the length spills to a second block
      for (int i = 0; i < 13; i++)
         send_word(i[0] ? 32'h0000_0000 : 32'hffff_ffff, 3'd4, 1'b0);
      send_word(32'h5a5a_5a5a, 3'd4, 1'b1);

      run_phase(6, 52);
      run_phase(52, 6);
      pressure_armed = 1'b1;
      run_phase(0, 0);

      @(posedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.report_leftovers();
      if (sb.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
rtl/sha256_pkg.sv
rtl/sha256_datapath.sv
rtl/sha256_ctrl.sv
rtl/sha256_hash_engine_unit.sv
sim/testbench.sv
